// ===== rtl/core/podu_pkg.sv =====
// ----------------------------------------------------------------------------
// podu_pkg
// Shared types, constants and dither matrices of the pixel ordered dither unit.
// ----------------------------------------------------------------------------
package podu_pkg;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned RandW    = 15;
  localparam int unsigned DitherW  = 3;
  localparam int unsigned NoiseW   = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  localparam logic [ChanW-1:0]  ChanSatLimit = 8'd247;
  localparam logic [ChanW-1:0]  ChanMax      = 8'hff;
  localparam logic [ChanW-1:0]  ChanStepMask = 8'hf8;
  localparam logic [5:0]        NoiseLowFill = 6'h20;
  localparam logic [DitherW-1:0] GreenRotOfs = 3'd3;
  localparam logic [DitherW-1:0] BlueRotOfs  = 3'd5;
  localparam logic [DitherW-1:0] ConstDither = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DITHER_MODE = 2'd0,
    CFG_RGB_SELECT  = 2'd1,
    CFG_HOLD_NOISE  = 2'd2,
    CFG_FIELD_SHIFT = 2'd3
  } cfg_idx_e;

  localparam logic [1:0] RgbSelRotate = 2'd2;

  // upper mode bits: colour source
  typedef enum logic [1:0] {
    CSRC_MAGIC  = 2'd0,
    CSRC_BAYER  = 2'd1,
    CSRC_RANDOM = 2'd2,
    CSRC_CONST  = 2'd3
  } csrc_e;

  // lower mode bits: alpha source
  typedef enum logic [1:0] {
    ASRC_MATRIX = 2'd0,
    ASRC_INVERT = 2'd1,
    ASRC_NOISE  = 2'd2,
    ASRC_ZERO   = 2'd3
  } asrc_e;

  typedef struct packed {
    logic [3:0] dither_mode;
    logic [1:0] rgb_select;
    logic       hold_noise;
    logic       field_shift;
  } cfg_t;

  typedef struct packed {
    logic [RandW-1:0]   color_dither;
    logic [DitherW-1:0] alpha_dither;
  } dither_t;

  function automatic logic [DitherW-1:0] magic4(input logic [3:0] idx);
    logic [DitherW-1:0] v;
    case (idx)
      4'd0:  v = 3'd0;  4'd1:  v = 3'd6;  4'd2:  v = 3'd1;  4'd3:  v = 3'd7;
      4'd4:  v = 3'd4;  4'd5:  v = 3'd2;  4'd6:  v = 3'd5;  4'd7:  v = 3'd3;
      4'd8:  v = 3'd3;  4'd9:  v = 3'd5;  4'd10: v = 3'd2;  4'd11: v = 3'd4;
      4'd12: v = 3'd7;  4'd13: v = 3'd1;  4'd14: v = 3'd6;  4'd15: v = 3'd0;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

  function automatic logic [DitherW-1:0] bayer4(input logic [3:0] idx);
    logic [DitherW-1:0] v;
    case (idx)
      4'd0:  v = 3'd0;  4'd1:  v = 3'd4;  4'd2:  v = 3'd1;  4'd3:  v = 3'd5;
      4'd4:  v = 3'd4;  4'd5:  v = 3'd0;  4'd6:  v = 3'd5;  4'd7:  v = 3'd1;
      4'd8:  v = 3'd3;  4'd9:  v = 3'd7;  4'd10: v = 3'd2;  4'd11: v = 3'd6;
      4'd12: v = 3'd7;  4'd13: v = 3'd3;  4'd14: v = 3'd6;  4'd15: v = 3'd2;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/podu_if.sv =====
// ----------------------------------------------------------------------------
// podu_if
// Pixel and result stream interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface podu_pix_if;
  logic                              valid;
  logic                              ready;
  logic [podu_pkg::CoordW-1:0]       pos_x;
  logic [podu_pkg::CoordW-1:0]       pos_y;
  logic [podu_pkg::ChanW-1:0]        red_in;
  logic [podu_pkg::ChanW-1:0]        green_in;
  logic [podu_pkg::ChanW-1:0]        blue_in;
  logic [podu_pkg::RandW-1:0]        noise_random;
  logic [podu_pkg::RandW-1:0]        color_random;

  modport source (output valid, pos_x, pos_y, red_in, green_in, blue_in,
                  noise_random, color_random, input ready);
  modport sink   (input valid, pos_x, pos_y, red_in, green_in, blue_in,
                  noise_random, color_random, output ready);
endinterface

interface podu_res_if;
  logic                              valid;
  logic                              ready;
  logic [podu_pkg::ChanW-1:0]        red_out;
  logic [podu_pkg::ChanW-1:0]        green_out;
  logic [podu_pkg::ChanW-1:0]        blue_out;
  logic [podu_pkg::RandW-1:0]        color_dither;
  logic [podu_pkg::DitherW-1:0]      alpha_dither;

  modport source (output valid, red_out, green_out, blue_out, color_dither,
                  alpha_dither, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, color_dither,
                  alpha_dither, output ready);
endinterface

// ===== rtl/core/podu_dither_sel.sv =====
// ----------------------------------------------------------------------------
// podu_dither_sel
// Matrix lookup and mode decode for the colour and alpha dither values.
// ----------------------------------------------------------------------------
module podu_dither_sel (
  input  podu_pkg::cfg_t                   cfg_i,
  input  logic [1:0]                       x_lo_i,
  input  logic [2:0]                       y_lo_i,
  input  logic [podu_pkg::RandW-1:0]       color_random_i,
  input  logic [podu_pkg::DitherW-1:0]     noise_i,
  output podu_pkg::dither_t                dither_o
);

  logic [1:0]                   y_sel;
  logic [3:0]                   idx;
  logic [podu_pkg::DitherW-1:0] mag;
  logic [podu_pkg::DitherW-1:0] bay;
  logic [podu_pkg::DitherW-1:0] mat;
  podu_pkg::csrc_e              csrc;
  podu_pkg::asrc_e              asrc;

  assign y_sel = cfg_i.field_shift ? y_lo_i[2:1] : y_lo_i[1:0];
  assign idx   = {y_sel, x_lo_i};
  assign mag   = podu_pkg::magic4(idx);
  assign bay   = podu_pkg::bayer4(idx);
  assign csrc  = podu_pkg::csrc_e'(cfg_i.dither_mode[3:2]);
  assign asrc  = podu_pkg::asrc_e'(cfg_i.dither_mode[1:0]);
  // alpha matrix: bayer for mode groups 4..7 and 12..15
  assign mat   = cfg_i.dither_mode[2] ? bay : mag;

  always_comb begin
    case (csrc)
      podu_pkg::CSRC_MAGIC:  dither_o.color_dither = podu_pkg::RandW'(mag);
      podu_pkg::CSRC_BAYER:  dither_o.color_dither = podu_pkg::RandW'(bay);
      podu_pkg::CSRC_RANDOM: dither_o.color_dither = color_random_i;
      podu_pkg::CSRC_CONST:  dither_o.color_dither = podu_pkg::RandW'(podu_pkg::ConstDither);
      default:               dither_o.color_dither = '0;
    endcase
    case (asrc)
      podu_pkg::ASRC_MATRIX: dither_o.alpha_dither = mat;
      podu_pkg::ASRC_INVERT: dither_o.alpha_dither = ~mat;
      podu_pkg::ASRC_NOISE:  dither_o.alpha_dither = noise_i;
      podu_pkg::ASRC_ZERO:   dither_o.alpha_dither = '0;
      default:               dither_o.alpha_dither = '0;
    endcase
  end

endmodule

// ===== rtl/core/podu_round.sv =====
// ----------------------------------------------------------------------------
// podu_round
// Rounds one channel up to the next multiple of 8 when the comparand is below
// its low three bits, saturating at full scale.
// ----------------------------------------------------------------------------
module podu_round (
  input  logic [podu_pkg::ChanW-1:0] chan_i,
  input  logic [podu_pkg::RandW-1:0] cmp_i,
  output logic [podu_pkg::ChanW-1:0] chan_o
);

  logic fire;

  assign fire = (cmp_i[podu_pkg::RandW-1:3] == '0) && (cmp_i[2:0] < chan_i[2:0]);

  always_comb begin
    if (!fire) begin
      chan_o = chan_i;
    end else if (chan_i > podu_pkg::ChanSatLimit) begin
      chan_o = podu_pkg::ChanMax;
    end else begin
      chan_o = (chan_i & podu_pkg::ChanStepMask) + podu_pkg::ChanW'(8);
    end
  end

endmodule

// ===== rtl/core/pixel_ordered_dither_unit.sv =====
// ----------------------------------------------------------------------------
// pixel_ordered_dither_unit
// Per-pixel ordered / random colour and alpha dither with channel rounding.
// ----------------------------------------------------------------------------
// One pixel per clock while the result side is ready: a pixel is captured in the
// input register, the matrix lookup, mode decode and channel rounding run in
// a single combinational pass, and the result lands in the output register.
// Either register accepts a new word whenever it is empty or its word is
// being taken in the same cycle, so a stalled output still lets one pixel in.
// The noise register reloads as each pixel passes the dither stage, unless held.
// Configuration must be written while no pixel is in flight.
// ----------------------------------------------------------------------------
module pixel_ordered_dither_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [podu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [podu_pkg::CfgDataW-1:0]  cfg_wdata_i,
  podu_pix_if.sink                       pix,
  podu_res_if.source                     res
);

  podu_pkg::cfg_t cfg_q;
  podu_pkg::cfg_idx_e cfg_idx;

  logic                           in_valid_q;
  logic [1:0]                     x_lo_q;
  logic [2:0]                     y_lo_q;
  logic [podu_pkg::ChanW-1:0]     red_q, green_q, blue_q;
  logic [2:0]                     nrand_q;
  logic [podu_pkg::RandW-1:0]     crand_q;

  logic [podu_pkg::NoiseW-1:0]    noise_q, noise_d;
  logic [podu_pkg::DitherW-1:0]   noise_cur;

  logic                           out_valid_q;
  logic [podu_pkg::ChanW-1:0]     red_out_q, green_out_q, blue_out_q;
  logic [podu_pkg::RandW-1:0]     cd_q;
  logic [podu_pkg::DitherW-1:0]   ad_q;

  logic                           in_fire, mid_fire, out_ready;
  podu_pkg::dither_t              dither;
  logic [podu_pkg::DitherW-1:0]   rot_g, rot_b;
  logic [podu_pkg::RandW-1:0]     cmp_g, cmp_b;
  logic [podu_pkg::ChanW-1:0]     red_d, green_d, blue_d;

  assign cfg_idx = podu_pkg::cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx)
        podu_pkg::CFG_DITHER_MODE: cfg_q.dither_mode <= cfg_wdata_i;
        podu_pkg::CFG_RGB_SELECT:  cfg_q.rgb_select  <= cfg_wdata_i[1:0];
        podu_pkg::CFG_HOLD_NOISE:  cfg_q.hold_noise  <= cfg_wdata_i[0];
        podu_pkg::CFG_FIELD_SHIFT: cfg_q.field_shift <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_ready = !out_valid_q || res.ready;
  assign pix.ready = !in_valid_q || out_ready;
  assign in_fire   = pix.valid && pix.ready;
  assign mid_fire  = in_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (pix.ready) begin
      in_valid_q <= pix.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_lo_q  <= pix.pos_x[1:0];
      y_lo_q  <= pix.pos_y[2:0];
      red_q   <= pix.red_in;
      green_q <= pix.green_in;
      blue_q  <= pix.blue_in;
      nrand_q <= pix.noise_random[2:0];
      crand_q <= pix.color_random;
    end
  end

  // noise register
  assign noise_d   = cfg_q.hold_noise ? noise_q : {nrand_q, podu_pkg::NoiseLowFill};
  assign noise_cur = noise_d[podu_pkg::NoiseW-1:6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= '0;
    end else if (mid_fire) begin
      noise_q <= noise_d;
    end
  end

  podu_dither_sel u_sel (
    .cfg_i          (cfg_q),
    .x_lo_i         (x_lo_q),
    .y_lo_i         (y_lo_q),
    .color_random_i (crand_q),
    .noise_i        (noise_cur),
    .dither_o       (dither)
  );

  // rotated comparands wrap within three bits
  assign rot_g = dither.color_dither[2:0] + podu_pkg::GreenRotOfs;
  assign rot_b = dither.color_dither[2:0] + podu_pkg::BlueRotOfs;

  always_comb begin
    if (cfg_q.rgb_select == podu_pkg::RgbSelRotate) begin
      cmp_g = podu_pkg::RandW'(rot_g);
      cmp_b = podu_pkg::RandW'(rot_b);
    end else begin
      cmp_g = dither.color_dither;
      cmp_b = dither.color_dither;
    end
  end

  podu_round u_round_r (.chan_i(red_q),   .cmp_i(dither.color_dither), .chan_o(red_d));
  podu_round u_round_g (.chan_i(green_q), .cmp_i(cmp_g),               .chan_o(green_d));
  podu_round u_round_b (.chan_i(blue_q),  .cmp_i(cmp_b),               .chan_o(blue_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_fire) begin
      red_out_q   <= red_d;
      green_out_q <= green_d;
      blue_out_q  <= blue_d;
      cd_q        <= dither.color_dither;
      ad_q        <= dither.alpha_dither;
    end
  end

  assign res.valid        = out_valid_q;
  assign res.red_out      = red_out_q;
  assign res.green_out    = green_out_q;
  assign res.blue_out     = blue_out_q;
  assign res.color_dither = cd_q;
  assign res.alpha_dither = ad_q;

  a_noise_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_fire && cfg_q.hold_noise |=> $stable(noise_q))
    else $error("noise register changed while held");

  a_noise_reload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_fire && !cfg_q.hold_noise |=> noise_q[5:0] == podu_pkg::NoiseLowFill)
    else $error("noise reload pattern wrong");

  a_narrow_dither : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && cfg_q.dither_mode[3:2] != podu_pkg::CSRC_RANDOM
      |-> cd_q[podu_pkg::RandW-1:3] == '0)
    else $error("non-random colour dither exceeds three bits");

  a_mid_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_fire |=> out_valid_q)
    else $error("pixel lost between stages");

endmodule

// ===== tb/sv/tb_pixel_ordered_dither_unit.sv =====
// ----------------------------------------------------------------------------
// tb_pixel_ordered_dither_unit
// Self-checking bench for the ordered dither unit. Pixels stream in under
// random sender gaps and result stalls. Every accepted pixel is run through a
// predictor that covers matrix lookup, noise reload, mode decode, green/blue
// rotation and channel rounding, and the result stream is checked in order.
// The configuration is changed between phases only when the unit is empty.
// The phases sweep all sixteen modes, the rgb select values and the noise
// hold and field shift settings.
// ----------------------------------------------------------------------------
module tb_pixel_ordered_dither_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [podu_pkg::CoordW-1:0] pos_x;
    logic [podu_pkg::CoordW-1:0] pos_y;
    logic [podu_pkg::ChanW-1:0]  red;
    logic [podu_pkg::ChanW-1:0]  green;
    logic [podu_pkg::ChanW-1:0]  blue;
    logic [podu_pkg::RandW-1:0]  noise_random;
    logic [podu_pkg::RandW-1:0]  color_random;
  } pixel_t;

  typedef struct packed {
    logic [podu_pkg::ChanW-1:0]   red;
    logic [podu_pkg::ChanW-1:0]   green;
    logic [podu_pkg::ChanW-1:0]   blue;
    logic [podu_pkg::RandW-1:0]   color_dither;
    logic [podu_pkg::DitherW-1:0] alpha_dither;
  } dithered_t;

  localparam int unsigned MAGIC_TBL[16] = '{0, 6, 1, 7, 4, 2, 5, 3, 3, 5, 2, 4, 7, 1, 6, 0};
  localparam int unsigned BAYER_TBL[16] = '{0, 4, 1, 5, 4, 0, 5, 1, 3, 7, 2, 6, 7, 3, 6, 2};
  localparam int NUM_PHASES = 24;
  localparam int PHASE_LEN  = 31;

  class dither_scoreboard;
    podu_pkg::cfg_t cfg;
    logic [8:0]     noise_q = '0;
    dithered_t      pending_px[$];
    int             errors;
    int             seen;

    function logic [podu_pkg::ChanW-1:0] round_up(logic [podu_pkg::ChanW-1:0] c,
                                                  int unsigned cmp);
      if (cmp < c[2:0])
        return (c > podu_pkg::ChanSatLimit) ? podu_pkg::ChanMax
                                            : (c & podu_pkg::ChanStepMask) + 8'd8;
      return c;
    endfunction

    function void predict_pixel(pixel_t p);
      logic [podu_pkg::CoordW-1:0] ysh;
      logic [3:0]                  idx;
      int unsigned                 mag, bay, mtx, cd, ad, cg, cb;
      podu_pkg::csrc_e             csel;
      podu_pkg::asrc_e             asel;
      dithered_t                   e;
      if (!cfg.hold_noise) noise_q = {p.noise_random[2:0], podu_pkg::NoiseLowFill};
      ysh  = p.pos_y >> cfg.field_shift;
      idx  = {ysh[1:0], p.pos_x[1:0]};
      mag  = MAGIC_TBL[idx];
      bay  = BAYER_TBL[idx];
      csel = podu_pkg::csrc_e'(cfg.dither_mode[3:2]);
      asel = podu_pkg::asrc_e'(cfg.dither_mode[1:0]);
      case (csel)
        podu_pkg::CSRC_MAGIC:  cd = mag;
        podu_pkg::CSRC_BAYER:  cd = bay;
        podu_pkg::CSRC_RANDOM: cd = p.color_random;
        default:               cd = podu_pkg::ConstDither;
      endcase
      mtx = (csel == podu_pkg::CSRC_MAGIC || csel == podu_pkg::CSRC_RANDOM) ? mag : bay;
      case (asel)
        podu_pkg::ASRC_MATRIX: ad = mtx;
        podu_pkg::ASRC_INVERT: ad = 7 - mtx;
        podu_pkg::ASRC_NOISE:  ad = noise_q[8:6];
        default:               ad = 0;
      endcase
      if (cfg.rgb_select == podu_pkg::RgbSelRotate) begin
        cg = (cd + podu_pkg::GreenRotOfs) & 7;
        cb = (cd + podu_pkg::BlueRotOfs) & 7;
      end else begin
        cg = cd;
        cb = cd;
      end
      e.red          = round_up(p.red, cd);
      e.green        = round_up(p.green, cg);
      e.blue         = round_up(p.blue, cb);
      e.color_dither = cd[podu_pkg::RandW-1:0];
      e.alpha_dither = ad[podu_pkg::DitherW-1:0];
      pending_px.push_back(e);
    endfunction

    function void compare_pixel(dithered_t r);
      dithered_t e;
      seen++;
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("word %0d: unexpected r=%0d g=%0d b=%0d cd=%0d ad=%0d",
                   seen, r.red, r.green, r.blue, r.color_dither, r.alpha_dither);
        return;
      end
      e = pending_px.pop_front();
      if (r.red !== e.red || r.green !== e.green || r.blue !== e.blue ||
          r.color_dither !== e.color_dither || r.alpha_dither !== e.alpha_dither) begin
        errors++;
        if (errors <= 10)
          $display({"word %0d: got r=%0d g=%0d b=%0d cd=%0d ad=%0d, ",
                    "want r=%0d g=%0d b=%0d cd=%0d ad=%0d"},
                   seen, r.red, r.green, r.blue, r.color_dither, r.alpha_dither,
                   e.red, e.green, e.blue, e.color_dither, e.alpha_dither);
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  podu_pkg::cfg_idx_e            cfg_idx_i;
  logic [podu_pkg::CfgDataW-1:0] cfg_wdata_i;
  bit                            calm;
  int                            stall_left;

  dither_scoreboard sb = new();

  podu_pix_if pix_if ();
  podu_res_if res_if ();

  pixel_ordered_dither_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix         (pix_if),
    .res         (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("pixel_ordered_dither_unit test failed");
    $finish;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function logic [podu_pkg::ChanW-1:0] pick_chan();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return podu_pkg::ChanW'($urandom_range(248, 255));
    if (r < 40) return podu_pkg::ChanW'($urandom_range(0, 7));
    return podu_pkg::ChanW'($urandom_range(0, 255));
  endfunction

  function pixel_t random_pixel();
    pixel_t p;
    p.pos_x        = podu_pkg::CoordW'($urandom_range(0, 4095));
    p.pos_y        = podu_pkg::CoordW'($urandom_range(0, 4095));
    p.red          = pick_chan();
    p.green        = pick_chan();
    p.blue         = pick_chan();
    p.noise_random = podu_pkg::RandW'($urandom_range(0, 32767));
    p.color_random = ($urandom_range(0, 1) != 0) ? podu_pkg::RandW'($urandom_range(0, 32767))
                                                 : podu_pkg::RandW'($urandom_range(0, 15));
    return p;
  endfunction

  // result side: random stalls, no new stall starts while calm
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (calm || $urandom_range(0, 3) != 0) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= 1'b0;
      stall_left   <= ($urandom_range(0, 4) != 0) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        sb.compare_pixel('{red: res_if.red_out, green: res_if.green_out,
                           blue: res_if.blue_out, color_dither: res_if.color_dither,
                           alpha_dither: res_if.alpha_dither});
      if (pix_if.valid && pix_if.ready)
        sb.predict_pixel('{pos_x: pix_if.pos_x, pos_y: pix_if.pos_y, red: pix_if.red_in,
                           green: pix_if.green_in, blue: pix_if.blue_in,
                           noise_random: pix_if.noise_random,
                           color_random: pix_if.color_random});
    end
  end

  task automatic drive_fields(pixel_t p);
    pix_if.pos_x        <= p.pos_x;
    pix_if.pos_y        <= p.pos_y;
    pix_if.red_in       <= p.red;
    pix_if.green_in     <= p.green;
    pix_if.blue_in      <= p.blue;
    pix_if.noise_random <= p.noise_random;
    pix_if.color_random <= p.color_random;
  endtask

  task automatic send_pixel(pixel_t p, int gap);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    drive_fields(p);
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  task automatic drain();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_cfg(podu_pkg::cfg_t c);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= podu_pkg::CFG_DITHER_MODE;
    cfg_wdata_i <= c.dither_mode;
    @(posedge clk_i);
    cfg_idx_i   <= podu_pkg::CFG_RGB_SELECT;
    cfg_wdata_i <= {2'b00, c.rgb_select};
    @(posedge clk_i);
    cfg_idx_i   <= podu_pkg::CFG_HOLD_NOISE;
    cfg_wdata_i <= {3'b000, c.hold_noise};
    @(posedge clk_i);
    cfg_idx_i   <= podu_pkg::CFG_FIELD_SHIFT;
    cfg_wdata_i <= {3'b000, c.field_shift};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.cfg = c;
  endtask

  initial begin : stimulus
    pixel_t         p;
    podu_pkg::cfg_t c;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= podu_pkg::CFG_DITHER_MODE;
    cfg_wdata_i  <= '0;
    pix_if.valid <= 1'b0;
    drive_fields('0);
    calm = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    program_cfg('0);

    send_pixel('0, 0);
    send_pixel('{pos_x: 12'hfff, pos_y: 12'hfff, red: 8'hff, green: 8'hff, blue: 8'hff,
                 noise_random: 15'h7fff, color_random: 15'h7fff}, 1);
    // full 4x4 matrix sweep; 255 saturates, 247 steps to 248 where the matrix value is below 7
    for (int i = 0; i < 16; i++) begin
      p = '{pos_x: podu_pkg::CoordW'(i % 4), pos_y: podu_pkg::CoordW'(i / 4),
            red: 8'd255, green: 8'd7, blue: 8'd247,
            noise_random: podu_pkg::RandW'(i * 2047),
            color_random: podu_pkg::RandW'(i)};
      send_pixel(p, i % 3);
    end
    send_pixel('{pos_x: 12'd5, pos_y: 12'd9, red: 8'd250, green: 8'd248, blue: 8'd1,
                 noise_random: 15'd3, color_random: 15'd8}, 0);

    for (int k = 0; k < NUM_PHASES; k++) begin
      drain();
      c.dither_mode = (k < 16) ? k[3:0] : 4'($urandom_range(0, 15));
      c.rgb_select  = (k % 3 == 2) ? podu_pkg::RgbSelRotate : 2'($urandom_range(0, 3));
      c.hold_noise  = 1'($urandom_range(0, 1));
      c.field_shift = 1'($urandom_range(0, 1));
      if (k == 0) c = '0;
      if (k == 15) c = '1;
      program_cfg(c);
      calm = (k % 5 == 3);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (k == 10 && n == 15) drain();
        send_pixel(random_pixel(), calm ? 0 : pick_gap());
      end
    end

    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_px.size() == 0)
      $display("pixel_ordered_dither_unit test passed");
    else
      $display("pixel_ordered_dither_unit test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/podu_pkg.sv
rtl/core/podu_if.sv
rtl/core/podu_dither_sel.sv
rtl/core/podu_round.sv
rtl/core/pixel_ordered_dither_unit.sv
tb/sv/tb_pixel_ordered_dither_unit.sv
